>>> rtl/core/min_delay_phase_derotator_top_defines.svh
// Assertion macros for the phase derotator.
`ifndef MIN_DELAY_PHASE_DEROTATOR_TOP_DEFINES_SVH
`define MIN_DELAY_PHASE_DEROTATOR_TOP_DEFINES_SVH
`ifndef SYNTH
`define MDPD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MDPD_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MDPD_ASSERT_IMP(label, clk, rstn, ante, cons)
`define MDPD_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/core/mdpd_pkg.sv
package mdpd_pkg;
    localparam int DefChannels = 64;
    localparam int DefStages = 20;
    localparam logic [63:0] InvTwoPi = 64'h28BE60DB9391054A;
    localparam logic [31:0] InvGain = 32'd2608131496;
    localparam int Guard = 6;
    localparam int XW = 24 + Guard + 3;

    localparam logic [1:0] CMD_FIRST = 2'd0;
    localparam logic [1:0] CMD_FURTHER = 2'd1;
    localparam logic [1:0] CMD_ROTATE = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam logic REG_USE_SHARED = 1'b0;
    localparam logic REG_SHARED = 1'b1;

    typedef struct packed {
        logic [1:0] cmd;
        logic [5:0] channel;
        logic signed [31:0] delay_sample;
        logic signed [31:0] omega;
        logic signed [23:0] sample_re;
        logic signed [23:0] sample_im;
    } in_item_t;

    typedef struct packed {
        logic kind;
        logic [5:0] out_channel;
        logic signed [31:0] min_delay;
        logic signed [23:0] out_re;
        logic signed [23:0] out_im;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_MUL, ST_PHASE, ST_ROT, ST_CORDIC, ST_GAIN, ST_OUT
    } state_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
            5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
            5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
            5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
            5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
            5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
            5'd20: r = 32'd652;       5'd21: r = 32'd326;
            5'd22: r = 32'd163;       5'd23: r = 32'd81;
            5'd24: r = 32'd41;        5'd25: r = 32'd20;
            5'd26: r = 32'd10;        5'd27: r = 32'd5;
            5'd28: r = 32'd3;         5'd29: r = 32'd1;
            5'd30: r = 32'd1;         default: r = 32'd0;
        endcase
        return r;
    endfunction
endpackage

>>> rtl/core/min_delay_phase_derotator_top.sv
// Minimum-delay table with phase derotation.
// Requests enter on s_valid/s_ready carrying an in_item_t; results leave on
// m_valid/m_ready as an out_item_t. Delay requests (cmd 0 and 1) read the
// channel's entry from a synchronous memory, update the running minimum,
// write it back and pass through the OUT state before m_valid rises.
// Rotate requests (cmd 2) form omega*delay, scale it into turns with four
// 32-bit partial products, start the shared CORDIC unit in the next cycle,
// run it until it reports done, then apply the gain to each axis in turn
// and pass through the OUT state before m_valid rises. One request is in
// flight at a time and the next is taken the cycle after the result leaves.
// cmd 3 is dropped without a result. The result sits in an output register
// and the block waits, without taking new requests, while the receiver
// stalls. Reset clears the control state and configuration; table entries
// are undefined until written by cmd 0. The user must write configuration
// by cfg_we/cfg_index/cfg_data only while the block is idle; the block
// itself does not enforce this.
`include "min_delay_phase_derotator_top_defines.svh"
module min_delay_phase_derotator_top #(
    parameter int CHANNELS = mdpd_pkg::DefChannels,
    parameter int ROTATOR_STAGES = mdpd_pkg::DefStages
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  mdpd_pkg::in_item_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output mdpd_pkg::out_item_t m_data,
    input  logic cfg_we,
    input  logic cfg_index,
    input  logic [31:0] cfg_data
);
    import mdpd_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Delay table memory, read and written in one clocked block.
    logic [31:0] mem [CHANNELS];
    logic [31:0] rd_reg;
    logic we;
    logic [AW-1:0] waddr;
    logic [31:0] wdata;

    state_t st_reg, st_next;
    in_item_t req_reg;
    logic [AW-1:0] idx_reg;
    logic use_shared_reg;
    logic signed [31:0] shared_reg;
    logic signed [31:0] dly_reg;
    logic signed [63:0] prod_reg;
    logic [1:0] mstep_reg;
    logic [127:0] acc_reg;
    logic [31:0] phase_reg;
    logic rot_start;
    logic rot_done;
    logic signed [XW-1:0] rx, ry;
    logic gstep_reg;
    logic signed [23:0] ore_reg, oim_reg;
    logic out_valid_reg;
    out_item_t out_reg;
    logic [AW-1:0] s_idx;

    // Channel numbers wrap modulo the table depth. A short restoring
    // remainder does this with compares and subtracts only.
    function automatic logic [5:0] chan_mod(input logic [5:0] c);
        logic [16:0] r;
        r = 17'(c);
        for (int i = 5; i >= 0; i--) begin
            if (r >= (17'(CHANNELS) << i)) r = r - (17'(CHANNELS) << i);
        end
        return 6'(r);
    endfunction

    assign s_idx = AW'(chan_mod(s_data.channel));

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rd_reg <= mem[s_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_shared_reg <= 1'b0;
            shared_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_USE_SHARED: use_shared_reg <= cfg_data[0];
                default: shared_reg <= cfg_data;
            endcase
        end
    end

    assign s_ready = (st_reg == ST_IDLE) && !out_valid_reg;

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: if (s_valid && s_ready && s_data.cmd != CMD_NONE) st_next = ST_READ;
            ST_READ: st_next = (req_reg.cmd == CMD_ROTATE) ? ST_MUL : ST_OUT;
            ST_MUL: st_next = ST_PHASE;
            ST_PHASE: if (mstep_reg == 2'd3) st_next = ST_ROT;
            ST_ROT: st_next = ST_CORDIC;
            ST_CORDIC: if (rot_done) st_next = ST_GAIN;
            ST_GAIN: if (gstep_reg) st_next = ST_OUT;
            ST_OUT: st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    // Delay update: write the new minimum back in the READ state. The
    // rotator is started in the ROT state, after the PHASE state loads phase_reg.
    logic signed [31:0] newmin;
    always_comb begin
        we = 1'b0;
        waddr = idx_reg;
        rot_start = 1'b0;
        newmin = (req_reg.cmd == CMD_FIRST ||
                  req_reg.delay_sample < signed'(rd_reg)) ? req_reg.delay_sample
                                                          : signed'(rd_reg);
        wdata = newmin;
        unique case (st_reg)
            ST_READ: we = (req_reg.cmd != CMD_ROTATE);
            ST_ROT: rot_start = 1'b1;
            default: ;
        endcase
    end

    mdpd_rotator #(.STAGES(ROTATOR_STAGES)) u_rot (
        .aclk(aclk), .aresetn(aresetn), .start(rot_start), .phase(phase_reg),
        .in_re(req_reg.sample_re), .in_im(req_reg.sample_im),
        .done(rot_done), .x_out(rx), .y_out(ry)
    );

    // Gain product, one axis per cycle through a single multiplier.
    logic signed [XW+33:0] gp;
    logic signed [XW+33:0] gr;
    logic signed [XW-1:0] gsel;
    logic signed [23:0] gsat;
    always_comb begin
        gsel = gstep_reg ? ry : rx;
        gp = gsel * signed'({1'b0, InvGain});
        gr = (gp + (XW+34)'(64'sd1 <<< 37)) >>> 38;
        if (gr > (XW+34)'(8388607)) gsat = 24'sd8388607;
        else if (gr < -(XW+34)'(8388608)) gsat = -24'sd8388608;
        else gsat = gr[23:0];
    end

    // Phase multiply: 64x64 from four unsigned 32x32 partial products, sign-corrected.
    logic [63:0] pp;
    logic [31:0] pa, pb;
    always_comb begin
        pa = mstep_reg[0] ? prod_reg[63:32] : prod_reg[31:0];
        pb = mstep_reg[1] ? InvTwoPi[63:32] : InvTwoPi[31:0];
        pp = pa * pb;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (st_reg == ST_OUT) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
        if (s_valid && s_ready) begin
            req_reg <= s_data;
            idx_reg <= s_idx;
        end
        case (st_reg)
            ST_READ: begin
                dly_reg <= (req_reg.cmd == CMD_ROTATE)
                    ? (use_shared_reg ? shared_reg : signed'(rd_reg)) : newmin;
                mstep_reg <= 2'd0;
                acc_reg <= '0;
                gstep_reg <= 1'b0;
            end
            ST_MUL: prod_reg <= req_reg.omega * dly_reg;
            ST_PHASE: begin
                acc_reg <= acc_reg + (128'(pp) << (32 * (mstep_reg[0] + mstep_reg[1])));
                mstep_reg <= mstep_reg + 2'd1;
                if (mstep_reg == 2'd3)
                    phase_reg <= 32'((acc_reg + (128'(pp) << 64)
                        - (prod_reg[63] ? (128'(InvTwoPi) << 64) : 128'd0)) >> 72);
            end
            ST_GAIN: begin
                if (gstep_reg) oim_reg <= gsat;
                else ore_reg <= gsat;
                gstep_reg <= 1'b1;
            end
            ST_OUT: begin
                out_reg.kind <= (req_reg.cmd == CMD_ROTATE);
                out_reg.out_channel <= req_reg.channel;
                out_reg.min_delay <= dly_reg;
                out_reg.out_re <= (req_reg.cmd == CMD_ROTATE) ? ore_reg : '0;
                out_reg.out_im <= (req_reg.cmd == CMD_ROTATE) ? oim_reg : '0;
            end
            default: ;
        endcase
    end

    assign m_valid = out_valid_reg;
    assign m_data = out_reg;

    `MDPD_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, st_reg != ST_IDLE, !s_ready)
    `MDPD_ASSERT_NXT(a_out_follows, aclk, aresetn, st_reg == ST_OUT, m_valid)
    `MDPD_ASSERT_IMP(a_write_only_delay, aclk, aresetn, we, req_reg.cmd != CMD_ROTATE)
endmodule

>>> rtl/core/mdpd_rotator.sv
module mdpd_rotator #(
    parameter int STAGES = mdpd_pkg::DefStages
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic start,
    input  logic [31:0] phase,
    input  logic signed [23:0] in_re,
    input  logic signed [23:0] in_im,
    output logic done,
    output logic signed [mdpd_pkg::XW-1:0] x_out,
    output logic signed [mdpd_pkg::XW-1:0] y_out
);
    import mdpd_pkg::*;

    localparam int NS = (STAGES > 32) ? 32 : STAGES;

    logic signed [XW-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [32:0] z_reg, z_next;
    logic [5:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic [1:0] q;
    logic signed [XW-1:0] xs, ys, dx, dy;
    logic [31:0] at;

    always_comb begin
        q = 2'((phase + 32'h2000_0000) >> 30);
        xs = XW'(in_re) <<< Guard;
        ys = XW'(in_im) <<< Guard;
        dx = y_reg >>> cnt_reg[4:0];
        dy = x_reg >>> cnt_reg[4:0];
        at = atan_turn(cnt_reg[4:0]);
        x_next = x_reg; y_next = y_reg; z_next = z_reg;
        cnt_next = cnt_reg; busy_next = busy_reg;
        if (start) begin
            case (q)
                2'd0: begin x_next = xs;  y_next = ys;  end
                2'd1: begin x_next = -ys; y_next = xs;  end
                2'd2: begin x_next = -xs; y_next = -ys; end
                default: begin x_next = ys; y_next = -xs; end
            endcase
            z_next = 33'(signed'(phase - {q, 30'd0}));
            cnt_next = '0;
            busy_next = (NS != 0);
        end else if (busy_reg) begin
            if (!z_reg[32]) begin
                x_next = x_reg - dx; y_next = y_reg + dy;
                z_next = z_reg - 33'(at);
            end else begin
                x_next = x_reg + dx; y_next = y_reg - dy;
                z_next = z_reg + 33'(at);
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(NS - 1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next; y_reg <= y_next; z_reg <= z_next; cnt_reg <= cnt_next;
        if (!aresetn) busy_reg <= 1'b0;
        else busy_reg <= busy_next;
    end

    assign done = !busy_reg && !start;
    assign x_out = x_reg;
    assign y_out = y_reg;
endmodule
